// ===== hdl/swak_pkg.sv =====
// ----------------------------------------------------------------------------
// swak_pkg
// Shared types and constants for the swept box time-of-impact block.
// ----------------------------------------------------------------------------
package swak_pkg;

  localparam int DW = 46;   // displacement width, units of 2^-21 pixel
  localparam int QW = 31;   // quotient magnitude bits

  localparam logic signed [31:0] T_INF     = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] T_NEG_INF = 32'sh8000_0000;
  localparam logic [30:0]        T_SAT     = 31'h7FFF_FFFE;
  localparam logic signed [31:0] T_ONE     = 32'sd32768;

  localparam logic [2:0] DIR_NONE   = 3'd0;
  localparam logic [2:0] DIR_LEFT   = 3'd1;
  localparam logic [2:0] DIR_RIGHT  = 3'd2;
  localparam logic [2:0] DIR_BOTTOM = 3'd3;
  localparam logic [2:0] DIR_TOP    = 3'd4;

  localparam logic OP_X = 1'b0;
  localparam logic OP_Y = 1'b1;

  localparam logic REG_FRAME_TIME = 1'b0;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_SUM, ST_DSET, ST_DRUN, ST_FIN
  } state_t;

  typedef struct packed {
    logic load;
    logic mul1;
    logic mul2;
    logic sum;
    logic div_start;
    logic div_step;
    logic div_store;
    logic div_sel;   // 0 entry, 1 exit
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic div_last;
    logic out_full;
  } stat_t;

endpackage

// ===== hdl/swept_aabb_kinematic.sv =====
// ----------------------------------------------------------------------------
// swept_aabb_kinematic
// Swept box time of impact over one frame, one axis per input transfer.
//
// Input stream: in_tuser selects the axis (0 x, 1 y); in_tdata carries the
// edges, velocities and accelerations. An x transfer computes and holds the
// x-axis entry and exit times and produces nothing. A y transfer combines
// its times with the held x figures and produces one output transfer:
// entry_time (Q1.15, 1.0 = no hit) in out_tdata, contact side in out_tuser.
// Each item runs from acceptance through two multiply steps and a sum
// for the displacement, then two 31-step restoring divisions through
// one shared divider, one quotient bit per cycle.
// One item is in flight at a time; in_tready is high only while idle,
// so a new item is not accepted until the last one has finished.
// The result sits in an output register; if the receiver stalls, the next y
// item waits at its last step until that register is taken. The user writes
// frame_time through the cfg_ APB port only while idle; it is not enforced.
// Reset clears the held x figures to an unmoving x axis, sets frame_time
// to 16 and drops out_tvalid.
// ----------------------------------------------------------------------------
module swept_aabb_kinematic import swak_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // mover_low, mover_high, other_low, other_high, mover_velocity,
  // mover_accel, other_velocity, other_accel
  input  logic [143:0] in_tdata,
  input  logic         in_tuser,   // op
  output logic         out_tvalid,
  input  logic         out_tready,
  output logic [15:0]  out_tdata,  // entry_time
  output logic [2:0]   out_tuser,  // direction
  input  logic         cfg_psel,
  input  logic         cfg_penable,
  input  logic         cfg_pwrite,
  input  logic [2:0]   cfg_paddr,
  input  logic [31:0]  cfg_pwdata,
  output logic [31:0]  cfg_prdata,
  output logic         cfg_pready
);

  cmd_t       cmd;
  stat_t      stat;
  logic [7:0] frame_r;

  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == REG_FRAME_TIME) ? {24'd0, frame_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r <= 8'd16;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready &&
                 cfg_paddr[2] == REG_FRAME_TIME) begin
      frame_r <= cfg_pwdata[7:0];
    end
  end

  swak_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  swak_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .frame     (frame_r),
    .in_op     (in_tuser),
    .in_data   (in_tdata),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_time  (out_tdata),
    .out_dir   (out_tuser)
  );

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready) else $error("accepted while busy");
  a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata <= 16'd32768) else $error("entry time out of range");
  a_dir: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tuser <= DIR_TOP) else $error("bad direction");
  a_none: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == DIR_NONE |-> out_tdata == 16'd32768)
    else $error("no hit without time 1.0");

endmodule

// ===== hdl/swak_ctrl.sv =====
// ----------------------------------------------------------------------------
// swak_ctrl
// Sequencer: load, multiply, sum, two serial divisions, then finish.
// ----------------------------------------------------------------------------
module swak_ctrl import swak_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t stat,
  output cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   sel_r, sel_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r   <= sel_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    sel_nxt   = sel_r;
    cmd       = '0;
    cmd.div_sel = sel_r;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_MUL1;
        end
      end
      ST_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = ST_MUL2;
      end
      ST_MUL2: begin
        cmd.mul2  = 1'b1;
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        cmd.sum   = 1'b1;
        sel_nxt   = 1'b0;
        state_nxt = ST_DSET;
      end
      ST_DSET: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DRUN;
      end
      ST_DRUN: begin
        if (stat.div_last) begin
          cmd.div_store = 1'b1;
          sel_nxt       = 1'b1;
          state_nxt     = sel_r ? ST_FIN : ST_DSET;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_FIN: begin
        if (!stat.out_full) begin
          cmd.finish = 1'b1;
          state_nxt  = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

// ===== hdl/swak_dp.sv =====
// ----------------------------------------------------------------------------
// swak_dp
// Datapath: displacement, gap select, restoring divider, axis combine.
// ----------------------------------------------------------------------------
module swak_dp import swak_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  cmd_t        cmd,
  output stat_t       stat,
  input  logic [7:0]  frame,
  input  logic        in_op,
  input  logic [143:0] in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_time,
  output logic [2:0]  out_dir
);

  logic                 op_r;
  logic signed [15:0]   ml_r, mh_r, ol_r, oh_r;
  logic signed [16:0]   v_r;
  logic signed [24:0]   a_r;
  logic signed [25:0]   vt_r;
  logic signed [33:0]   at_r;
  logic signed [42:0]   att_r;
  logic signed [DW-1:0] d_r;
  logic [DW-1:0]        nd_r;
  logic [DW-1:0]        rem_r;
  logic [QW-1:0]        q_r;
  logic [4:0]           cnt_r;
  logic                 sat_r, qneg_r;
  logic signed [31:0]   ent_r, ext_r;
  logic signed [31:0]   hent_r, hext_r;
  logic                 hstill_r, hneg_r;
  logic                 ovalid_r;
  logic [15:0]          otime_r;
  logic [2:0]           odir_r;

  logic signed [8:0]    ts;
  logic signed [16:0]   gap;
  logic [15:0]          ng;
  logic [DW:0]          trial;
  logic [QW-1:0]        mag;
  logic signed [31:0]   qval;
  logic                 still, dneg;
  logic signed [31:0]   ye, yx, xe, xx, ent_m, ext_m;
  logic                 nohit;
  logic [2:0]           dir;

  assign ts    = $signed({1'b0, frame});
  assign still = (d_r == '0);
  assign dneg  = d_r[DW-1];
  assign gap   = (cmd.div_sel != dneg) ? (17'(oh_r) - 17'(ml_r)) : (17'(ol_r) - 17'(mh_r));
  assign ng    = gap[16] ? 16'(-gap) : 16'(gap);
  assign trial = {rem_r, 1'b0};
  assign mag   = (sat_r || q_r == '1) ? T_SAT : q_r;
  assign qval  = qneg_r ? -$signed({1'b0, mag}) : $signed({1'b0, mag});

  assign ye    = still ? T_NEG_INF : ent_r;
  assign yx    = still ? T_INF : ext_r;
  assign xe    = hstill_r ? T_NEG_INF : hent_r;
  assign xx    = hstill_r ? T_INF : hext_r;
  assign ent_m = (xe > ye) ? xe : ye;
  assign ext_m = (xx < yx) ? xx : yx;
  assign nohit = (ent_m > ext_m) || (xe[31] && ye[31]) || (xe > T_ONE) || (ye > T_ONE);
  assign dir   = (xe >= ye) ? (hneg_r ? DIR_LEFT : DIR_RIGHT) : (dneg ? DIR_BOTTOM : DIR_TOP);

  assign stat.div_last = (cnt_r == '0);
  assign stat.out_full = ovalid_r && !out_ready && op_r == OP_Y;
  assign out_valid = ovalid_r;
  assign out_time  = otime_r;
  assign out_dir   = odir_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_op;
      ml_r <= in_data[15:0];
      mh_r <= in_data[31:16];
      ol_r <= in_data[47:32];
      oh_r <= in_data[63:48];
      v_r  <= 17'($signed(in_data[79:64])) - 17'($signed(in_data[119:104]));
      a_r  <= 25'($signed(in_data[103:80])) - 25'($signed(in_data[143:120]));
    end
    if (cmd.mul1) begin
      vt_r <= 26'(v_r * ts);
      at_r <= 34'(a_r * ts);
    end
    if (cmd.mul2) att_r <= 43'(at_r * ts);
    if (cmd.sum) begin
      d_r <= ((DW)'(vt_r) <<< 13) + ((DW)'(att_r) <<< 1) + (DW)'(att_r);
      nd_r <= d_r;
    end
    if (cmd.div_start) begin
      nd_r   <= dneg ? DW'(-d_r) : DW'(d_r);
      rem_r  <= DW'({ng, 5'b0});
      sat_r  <= (DW'({ng, 5'b0}) >= (dneg ? DW'(-d_r) : DW'(d_r)));
      qneg_r <= gap[16] != dneg;
      q_r    <= '0;
      cnt_r  <= 5'(QW);
    end
    if (cmd.div_step) begin
      cnt_r <= cnt_r - 5'd1;
      if (trial >= {1'b0, nd_r}) begin
        rem_r <= DW'(trial - {1'b0, nd_r});
        q_r   <= {q_r[QW-2:0], 1'b1};
      end else begin
        rem_r <= DW'(trial);
        q_r   <= {q_r[QW-2:0], 1'b0};
      end
    end
    if (cmd.div_store) begin
      if (cmd.div_sel) ext_r <= qval;
      else ent_r <= qval;
    end
    if (cmd.finish && op_r == OP_Y) begin
      otime_r <= nohit ? 16'(T_ONE) : ent_m[15:0];
      odir_r  <= nohit ? DIR_NONE : dir;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hent_r   <= '0;
      hext_r   <= '0;
      hstill_r <= 1'b1;
      hneg_r   <= 1'b0;
      ovalid_r <= 1'b0;
    end else begin
      if (cmd.finish && op_r == OP_X) begin
        hent_r   <= ye;
        hext_r   <= yx;
        hstill_r <= still;
        hneg_r   <= dneg;
      end
      if (cmd.finish && op_r == OP_Y) ovalid_r <= 1'b1;
      else if (out_ready) ovalid_r <= 1'b0;
    end
  end

endmodule

// ===== tb/swept_aabb_kinematic_tb.sv =====
// ----------------------------------------------------------------------------
// swept_aabb_kinematic_tb
// Self-checking bench for the swept box time-of-impact block. Axis items go
// in over the in_ stream under random bursts and gaps. A cycle-free predictor
// tracks the held x figures and frame_time and queues one expected contact
// time and side per y item. The out_ stream is checked in order while the
// receiver stalls on its own pattern, including one long hold-off.
// frame_time is swept through several values between phases.
// ----------------------------------------------------------------------------
module swept_aabb_kinematic_tb;
  import swak_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic       REG_SPARE = 1'b1;
  localparam int         DRAIN_CYCLES = 120;
  localparam int         STALL_LIMIT = 4000;
  localparam longint     SAT_MAG = 64'd2147483646;

  typedef struct {
    logic               op;
    logic signed [15:0] mover_low;
    logic signed [15:0] mover_high;
    logic signed [15:0] other_low;
    logic signed [15:0] other_high;
    logic signed [15:0] mover_velocity;
    logic signed [23:0] mover_accel;
    logic signed [15:0] other_velocity;
    logic signed [23:0] other_accel;
  } axis_item_t;

  typedef struct {
    logic [15:0] entry_time;
    logic [2:0]  direction;
  } contact_t;

  logic         clk;
  logic         rst_n;
  logic         in_tvalid;
  logic         in_tready;
  logic [143:0] in_tdata;
  logic         in_tuser;
  logic         out_tvalid;
  logic         out_tready;
  logic [15:0]  out_tdata;
  logic [2:0]   out_tuser;
  logic         cfg_psel;
  logic         cfg_penable;
  logic         cfg_pwrite;
  logic [2:0]   cfg_paddr;
  logic [31:0]  cfg_pwdata;
  logic [31:0]  cfg_prdata;
  logic         cfg_pready;

  swept_aabb_kinematic DUT (.*);

  axis_item_t pending_items[$];
  contact_t   expected_contacts[$];
  axis_item_t cur_item;
  int         errors;
  int         burst_left;
  int         gap_left;
  int         contacts_seen;
  int         stall_mode;
  int         hold_cnt;
  bit         hold_done;
  int         quiet_cycles;

  // predictor state
  longint     frame_len;
  longint     held_entry;
  longint     held_exit;
  bit         held_still;
  bit         held_negative;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [143:0] pack_item(axis_item_t it);
    return {it.other_accel, it.other_velocity, it.mover_accel, it.mover_velocity,
            it.other_high, it.other_low, it.mover_high, it.mover_low};
  endfunction

  function automatic longint gap_over_disp(longint gap, longint disp);
    longint ng;
    longint nd;
    longint q;
    ng = gap < 0 ? -gap : gap;
    nd = disp < 0 ? -disp : disp;
    q = (ng <<< 36) / nd;
    if (q > SAT_MAG) q = SAT_MAG;
    return ((gap < 0) != (disp < 0)) ? -q : q;
  endfunction

  task automatic axis_times(input axis_item_t it, output longint t_in, output longint t_out,
                            output bit still, output bit negative);
    longint v;
    longint a;
    longint d;
    v = longint'(it.mover_velocity) - longint'(it.other_velocity);
    a = longint'(it.mover_accel) - longint'(it.other_accel);
    d = v * frame_len * 8192 + 3 * a * frame_len * frame_len;
    still = (d == 0);
    negative = (d < 0);
    if (d == 0) begin
      t_in = longint'(T_NEG_INF);
      t_out = longint'(T_INF);
    end else if (d > 0) begin
      t_in = gap_over_disp(longint'(it.other_low) - longint'(it.mover_high), d);
      t_out = gap_over_disp(longint'(it.other_high) - longint'(it.mover_low), d);
    end else begin
      t_in = gap_over_disp(longint'(it.other_high) - longint'(it.mover_low), d);
      t_out = gap_over_disp(longint'(it.other_low) - longint'(it.mover_high), d);
    end
  endtask

  task automatic predict_contact(input axis_item_t it);
    longint   y_in;
    longint   y_out;
    longint   x_in;
    longint   x_out;
    longint   t_in;
    longint   t_out;
    bit       still;
    bit       negative;
    contact_t c;
    axis_times(it, y_in, y_out, still, negative);
    if (it.op == OP_X) begin
      held_entry = y_in;
      held_exit = y_out;
      held_still = still;
      held_negative = negative;
      return;
    end
    x_in = held_still ? longint'(T_NEG_INF) : held_entry;
    x_out = held_still ? longint'(T_INF) : held_exit;
    t_in = x_in > y_in ? x_in : y_in;
    t_out = x_out < y_out ? x_out : y_out;
    if (t_in > t_out || (x_in < 0 && y_in < 0) || x_in > longint'(T_ONE)
        || y_in > longint'(T_ONE)) begin
      c.entry_time = 16'd32768;
      c.direction = DIR_NONE;
    end else begin
      c.entry_time = t_in[15:0];
      if (x_in >= y_in) c.direction = held_negative ? DIR_LEFT : DIR_RIGHT;
      else c.direction = negative ? DIR_BOTTOM : DIR_TOP;
    end
    expected_contacts.push_back(c);
  endtask

  // driver
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else begin
      if (in_tvalid && in_tready) predict_contact(cur_item);
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left <= gap_left - 1;
          in_tvalid <= 1'b0;
        end else if (pending_items.size() > 0) begin
          cur_item = pending_items.pop_front();
          in_tdata <= pack_item(cur_item);
          in_tuser <= cur_item.op;
          in_tvalid <= 1'b1;
          if (burst_left <= 1) begin
            burst_left <= $urandom_range(1, 12);
            gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
          end else begin
            burst_left <= burst_left - 1;
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        contacts_seen <= contacts_seen + 1;
        if (expected_contacts.size() == 0) begin
          $error("unexpected transfer: entry_time %0d direction %0d", out_tdata, out_tuser);
          errors <= errors + 1;
        end else begin
          contact_t c;
          c = expected_contacts.pop_front();
          if (out_tdata !== c.entry_time) begin
            $error("entry_time expected %0d actual %0d", c.entry_time, out_tdata);
            errors <= errors + 1;
          end
          if (out_tuser !== c.direction) begin
            $error("direction expected %0d actual %0d", c.direction, out_tuser);
            errors <= errors + 1;
          end
        end
        if ($urandom_range(0, 40) == 0) stall_mode <= $urandom_range(0, 2);
      end
      if (!hold_done && contacts_seen == 150) begin
        hold_done <= 1'b1;
        hold_cnt <= 600;
        out_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        out_tready <= 1'b0;
      end else begin
        case (stall_mode)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          default: out_tready <= ($urandom_range(0, 7) == 0);
        endcase
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)
        || (cfg_psel && cfg_penable)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_write(input logic index, input logic [31:0] value);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr <= {index, 2'b00};
    cfg_pwdata <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (index == REG_FRAME_TIME) frame_len = longint'(value[7:0]);
  endtask

  task automatic drain();
    while (pending_items.size() > 0 || in_tvalid || expected_contacts.size() > 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function automatic axis_item_t random_item(logic op);
    axis_item_t it;
    int         shift;
    it.op = op;
    if ($urandom_range(0, 3) == 0) begin
      it.mover_low = 16'($urandom);
      it.mover_high = 16'($urandom);
      it.other_low = 16'($urandom);
      it.other_high = 16'($urandom);
      it.mover_velocity = 16'($urandom);
      it.mover_accel = 24'($urandom);
      it.other_velocity = 16'($urandom);
      it.other_accel = 24'($urandom);
    end else begin
      shift = $urandom_range(0, 14);
      it.mover_low = 16'($signed($urandom_range(0, 2000)) - 1000);
      it.mover_high = 16'(it.mover_low + $urandom_range(0, 60));
      it.other_low = 16'(it.mover_low + $signed($urandom_range(0, 300)) - 150);
      it.other_high = 16'(it.other_low + $urandom_range(0, 60));
      it.mover_velocity = 16'(($signed($urandom_range(0, 65535)) - 32768) >>> shift);
      it.other_velocity = ($urandom_range(0, 2) == 0) ?
                          16'(($signed($urandom_range(0, 65535)) - 32768) >>> shift)
                          : 16'sd0;
      it.mover_accel = ($urandom_range(0, 2) == 0) ?
                       24'(($signed($urandom_range(0, 16777215)) - 8388608)
                           >>> $urandom_range(8, 23))
                       : 24'sd0;
      it.other_accel = ($urandom_range(0, 3) == 0) ? 24'($urandom) : 24'sd0;
    end
    return it;
  endfunction

  function automatic axis_item_t fixed_item(logic op, int ml, int mh, int ol, int oh,
                                            int mv, int ma, int ov, int oa);
    axis_item_t it;
    it.op = op;
    it.mover_low = 16'(ml);
    it.mover_high = 16'(mh);
    it.other_low = 16'(ol);
    it.other_high = 16'(oh);
    it.mover_velocity = 16'(mv);
    it.mover_accel = 24'(ma);
    it.other_velocity = 16'(ov);
    it.other_accel = 24'(oa);
    return it;
  endfunction

  task automatic random_phase(input int n);
    int k;
    for (k = 0; k < n; k++) begin
      case ($urandom_range(0, 9))
        0: pending_items.push_back(random_item(OP_Y));
        1: pending_items.push_back(random_item(OP_X));
        default: begin
          pending_items.push_back(random_item(OP_X));
          pending_items.push_back(random_item(OP_Y));
          k++;
        end
      endcase
    end
    drain();
  endtask

  initial begin
    rst_n = 1'b0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = OP_X;
    out_tready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    errors = 0;
    contacts_seen = 0;
    stall_mode = 0;
    hold_cnt = 0;
    hold_done = 1'b0;
    quiet_cycles = 0;
    frame_len = 16;
    held_entry = 0;
    held_exit = 0;
    held_still = 1'b1;
    held_negative = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // y before any x, with the x axis still unmoving after reset
    pending_items.push_back(fixed_item(OP_Y, 0, 10, 20, 30, 1024, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, -30, -20, -1024, 0, 0, 0));
    // x axis moving, right then left contacts
    pending_items.push_back(fixed_item(OP_X, 0, 10, 15, 25, 2048, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, 5, 15, 256, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_X, 0, 10, -25, -15, -2048, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, 0, 10, 0, 0, 0, 0));
    // y axis decides, top then bottom
    pending_items.push_back(fixed_item(OP_X, 0, 10, 0, 10, 512, 0, 512, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, 20, 30, 1024, 1000, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, -30, -20, -1024, -1000, 0, 0));
    // both entries negative, and entry past the frame
    pending_items.push_back(fixed_item(OP_X, 0, 10, -30, -20, 100, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, -30, -20, 100, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 10, 3000, 3010, 1, 0, 0, 0));
    // field extremes and saturating quotients
    pending_items.push_back(fixed_item(OP_X, -32768, 32767, -32768, 32767,
                                       32767, 8388607, -32768, -8388608));
    pending_items.push_back(fixed_item(OP_Y, 32767, -32768, 32767, -32768,
                                       -32768, -8388608, 32767, 8388607));
    pending_items.push_back(fixed_item(OP_X, -32768, -32768, 32767, 32767, 1, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 32767, 32767, -32768, -32768, 0, 0, 1, 0));
    pending_items.push_back(fixed_item(OP_X, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, 0, 0, 0, 0, 0, 0, 0, 0));
    pending_items.push_back(fixed_item(OP_Y, -1, -1, -1, -1, -1, -1, -1, -1));
    drain();

    cfg_write(REG_SPARE, 32'd77);
    cfg_write(REG_FRAME_TIME, 32'd255);
    random_phase(300);
    cfg_write(REG_FRAME_TIME, 32'd1);
    random_phase(300);
    cfg_write(REG_FRAME_TIME, $urandom_range(2, 254));
    random_phase(400);
    cfg_write(REG_FRAME_TIME, 32'd16);
    random_phase(400);

    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
